// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

  // Fixed field widths of the access channel.
  localparam int ROW_IN_W  = 4;
  localparam int COL_IN_W  = 5;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  // Stored-entry offsets and counts are kept in 8 bits, as in the row word.
  localparam int IDX_W = 8;

  // Defaults for the top-level parameters.
  localparam int ROWS_DEF        = 16;
  localparam int MAX_COLS_DEF    = 24;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int NZ_CAPACITY_DEF = 255;

  localparam logic [COL_IN_W-1:0] NUM_COLS_RESET = COL_IN_W'(24);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Broadcast to every value cell.
  typedef struct packed {
    logic             insert;
    logic             overwrite;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] count;
  } bsm_cell_ctl_t;

  // Update of the row table on an insert.
  typedef struct packed {
    logic                insert;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
  } bsm_row_upd_t;

endpackage

// ===== rtl/bsm_if.sv =====
interface bsm_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [bsm_pkg::ROW_IN_W-1:0]   row_index;
  logic [bsm_pkg::COL_IN_W-1:0]   col_index;
  logic signed [bsm_pkg::DATA_W-1:0] write_value;

  modport source (output valid, command, row_index, col_index, write_value, input ready);
  modport sink   (input valid, command, row_index, col_index, write_value, output ready);
endinterface

interface bsm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsm_pkg::DATA_W-1:0] read_value;
  logic                              was_present;
  logic [bsm_pkg::STATUS_W-1:0]      status;

  modport source (output valid, read_value, was_present, status, input ready);
  modport sink   (input valid, read_value, was_present, status, output ready);
endinterface

// ===== rtl/bitmap_sparse_matrix_store_core.sv =====
// Sparse matrix store: each row keeps a column mask and the count of stored
// entries in earlier rows; the non-zero values sit in row-major order in a
// chain of NZ_CAPACITY value cells. One item is handled at a time. A write,
// a read of an absent entry and any rejected access pass through the S_LOOK
// and S_EXEC states before the result is registered. A read of a stored
// entry goes on to S_READ, where the read bus walks the value out through
// the cell chain one cell per cycle. An insert moves all later values up in
// the same cycle it updates the row table. The result sits in an output
// register, so the next item is accepted while it waits.
module bitmap_sparse_matrix_store_core #(
  parameter int ROWS        = bsm_pkg::ROWS_DEF,
  parameter int MAX_COLS    = bsm_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = bsm_pkg::VALUE_WIDTH_DEF,
  parameter int NZ_CAPACITY = bsm_pkg::NZ_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsm_pkg::COL_IN_W-1:0]  cfg_data,
  bsm_req_if.sink                       req,
  bsm_rsp_if.source                     rsp
);
  import bsm_pkg::*;

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RC_W = $clog2(NZ_CAPACITY + 1);
  localparam logic [RC_W-1:0]     RD_LAST  = RC_W'(NZ_CAPACITY);
  localparam logic [IDX_W-1:0]    CAP      = IDX_W'(NZ_CAPACITY);
  localparam logic [COL_IN_W-1:0] COLS_MAX = COL_IN_W'(MAX_COLS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                   cmd_q;
  logic [ROW_IN_W-1:0]    row_q;
  logic [COL_IN_W-1:0]    col_q;
  logic [VALUE_WIDTH-1:0] wv_q;
  logic [COL_IN_W-1:0]    num_cols;
  logic [IDX_W-1:0]       count_q;
  logic [IDX_W-1:0]       k_q;
  logic                   present_q;
  logic                   err_q;
  logic [RC_W-1:0]        rd_cnt;

  logic [MAX_COLS-1:0]    look_mask;
  logic [IDX_W-1:0]       look_base;
  logic [COL_IN_W-1:0]    eff_cols;
  logic                   err_c;
  logic [CW-1:0]          cidx;
  logic [COL_IN_W-1:0]    pop;
  logic [IDX_W-1:0]       k_c;

  logic                   out_free;
  logic                   emit;
  logic [STATUS_W-1:0]    emit_status;
  logic                   emit_present;
  logic signed [DATA_W-1:0] emit_value;
  bsm_cell_ctl_t          cell_ctl;
  bsm_row_upd_t           row_upd;

  logic [VALUE_WIDTH-1:0] cell_value [NZ_CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_bus   [NZ_CAPACITY];

  bsm_row_table #(
    .ROWS     (ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_rows (
    .clk       (clk),
    .rst       (rst),
    .upd       (row_upd),
    .look_row  (row_q),
    .look_mask (look_mask),
    .look_base (look_base)
  );

  for (genvar m = 0; m < NZ_CAPACITY; m++) begin : g_cell
    logic [VALUE_WIDTH-1:0] pv;
    logic [VALUE_WIDTH-1:0] pb;
    if (m == 0) begin : g_first
      assign pv = '0;
      assign pb = '0;
    end else begin : g_next
      assign pv = cell_value[m-1];
      assign pb = cell_bus[m-1];
    end
    bsm_value_cell #(
      .IDX         (m),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .wdata      (wv_q),
      .prev_value (pv),
      .prev_bus   (pb),
      .value      (cell_value[m]),
      .bus        (cell_bus[m])
    );
  end

  // Lookup of the addressed entry from the registered item.
  assign eff_cols = (num_cols > COLS_MAX) ? COLS_MAX : num_cols;
  assign err_c    = (int'(row_q) >= ROWS) || (col_q >= eff_cols);
  assign cidx     = CW'(col_q);

  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (COL_IN_W'(i) < col_q) begin
        pop = pop + COL_IN_W'(look_mask[i]);
      end
    end
  end

  assign k_c = look_base + IDX_W'(pop);

  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_present = 1'b0;
    emit_value   = '0;
    cell_ctl     = '{insert: 1'b0, overwrite: 1'b0, k: k_q, count: count_q};
    row_upd      = '{insert: 1'b0, row: row_q, col: col_q};
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (err_q) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_RANGE;
            state_next  = S_IDLE;
          end
        end else if (cmd_q == CMD_READ) begin
          if (present_q) begin
            state_next = S_READ;
          end else if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (present_q) begin
          if (out_free) begin
            emit               = 1'b1;
            emit_present       = 1'b1;
            cell_ctl.overwrite = 1'b1;
            state_next         = S_IDLE;
          end
        end else if (count_q >= CAP) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
            state_next  = S_IDLE;
          end
        end else if (out_free) begin
          emit            = 1'b1;
          cell_ctl.insert = 1'b1;
          row_upd.insert  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_READ: begin
        if (rd_cnt == RD_LAST && out_free) begin
          emit         = 1'b1;
          emit_present = 1'b1;
          emit_value   = DATA_W'($signed(cell_bus[NZ_CAPACITY-1]));
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      num_cols  <= NUM_COLS_RESET;
      count_q   <= '0;
      rd_cnt    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_cols <= cfg_data;
      end
      if (cell_ctl.insert) begin
        count_q <= count_q + IDX_W'(1);
      end
      if (state == S_EXEC) begin
        rd_cnt <= '0;
      end else if (state == S_READ && rd_cnt != RD_LAST) begin
        rd_cnt <= rd_cnt + RC_W'(1);
      end
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q <= req.command;
      row_q <= req.row_index;
      col_q <= req.col_index;
      wv_q  <= VALUE_WIDTH'($signed(req.write_value));
    end
    if (state == S_LOOK) begin
      k_q       <= k_c;
      err_q     <= err_c;
      present_q <= !err_c && look_mask[cidx];
    end
    if (emit) begin
      rsp.read_value  <= emit_value;
      rsp.was_present <= emit_present;
      rsp.status      <= emit_status;
    end
  end

endmodule

// ===== rtl/bsm_value_cell.sv =====
module bsm_value_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = bsm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  bsm_pkg::bsm_cell_ctl_t   ctl,
  input  logic [VALUE_WIDTH-1:0]   wdata,
  input  logic [VALUE_WIDTH-1:0]   prev_value,
  input  logic [VALUE_WIDTH-1:0]   prev_bus,
  output logic [VALUE_WIDTH-1:0]   value,
  output logic [VALUE_WIDTH-1:0]   bus
);
  import bsm_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic hit;
  logic in_shift;

  assign hit      = (ctl.k == MY_IDX);
  assign in_shift = (MY_IDX > ctl.k) && (MY_IDX <= ctl.count);

  // On insert, cells from slot+1 to count take the lower neighbor's value.
  always_ff @(posedge clk) begin
    if ((ctl.insert || ctl.overwrite) && hit) begin
      value <= wdata;
    end else if (ctl.insert && in_shift) begin
      value <= prev_value;
    end
  end

  // Read bus: the addressed cell launches its value, all others pass along.
  always_ff @(posedge clk) begin
    bus <= hit ? value : prev_bus;
  end

endmodule

// ===== rtl/bsm_row_table.sv =====
module bsm_row_table #(
  parameter int ROWS     = bsm_pkg::ROWS_DEF,
  parameter int MAX_COLS = bsm_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsm_pkg::bsm_row_upd_t         upd,
  input  logic [bsm_pkg::ROW_IN_W-1:0]  look_row,
  output logic [MAX_COLS-1:0]           look_mask,
  output logic [bsm_pkg::IDX_W-1:0]     look_base
);
  import bsm_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [MAX_COLS-1:0] mask [ROWS];
  logic [IDX_W-1:0]    base [ROWS];
  logic [RW-1:0]       ridx;
  logic [RW-1:0]       uidx;
  logic [CW-1:0]       ucol;
  logic                look_ok;

  assign ridx    = RW'(look_row);
  assign uidx    = RW'(upd.row);
  assign ucol    = CW'(upd.col);
  assign look_ok = (int'(look_row) < ROWS);

  assign look_mask = look_ok ? mask[ridx] : '0;
  assign look_base = look_ok ? base[ridx] : '0;

  // Base counts of all later rows step up together with the new mask bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        mask[r] <= '0;
        base[r] <= '0;
      end
    end else if (upd.insert) begin
      for (int r = 0; r < ROWS; r++) begin
        if (r == int'(uidx)) begin
          mask[r][ucol] <= 1'b1;
        end
        if (r > int'(uidx)) begin
          base[r] <= base[r] + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/bsm_checker.sv =====
module bsm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [bsm_pkg::DATA_W-1:0] rsp_read_value,
  input logic                              rsp_was_present,
  input logic [bsm_pkg::STATUS_W-1:0]      rsp_status
);
  import bsm_pkg::*;

  // A held result does not change while the sink stalls.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
      && $stable(rsp_status) && $stable(rsp_was_present))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while another is in work");

  // Rejected accesses return zero and report no stored entry.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_FULL)
      |-> rsp_read_value == '0 && !rsp_was_present)
    else $error("rejected access carries data");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind bitmap_sparse_matrix_store_core bsm_checker u_bsm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_value  (rsp.read_value),
  .rsp_was_present (rsp.was_present),
  .rsp_status      (rsp.status)
);

// ===== dv/bsm_store_checker.sv =====
module bsm_store_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bsm_pkg::COL_IN_W-1:0] cfg_data,
  bsm_req_if                           req,
  bsm_rsp_if                           rsp,
  output int                           fail_count,
  output int                           outstanding
);
  import bsm_pkg::*;

  localparam int STORE_DEPTH = 256;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic                present;
    logic [STATUS_W-1:0] status;
  } access_result_t;

  // Each row word: bits 31..24 count entries in earlier rows, 23..0 the column mask.
  logic [31:0]         row_table [ROWS_DEF];
  logic [DATA_W-1:0]   value_slots [STORE_DEPTH];
  int                  stored_total;
  logic [COL_IN_W-1:0] col_limit;
  access_result_t      expected_results [$];
  int                  mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_access(input logic cmd, input logic [ROW_IN_W-1:0] row,
                                input logic [COL_IN_W-1:0] col,
                                input logic [DATA_W-1:0] wr_value,
                                output access_result_t res);
    int          eff_cols;
    logic [31:0] word;
    logic [23:0] below;
    logic [7:0]  slot;
    logic        present;
    res = '0;
    res.status = ST_OK;
    eff_cols = (int'(col_limit) > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(col_limit);
    if (int'(row) >= ROWS_DEF || int'(col) >= eff_cols) begin
      res.status = ST_RANGE;
      return;
    end
    word    = row_table[row];
    below   = (24'd1 << col) - 24'd1;
    slot    = word[31:24] + 8'($countones(word[23:0] & below));
    present = word[col];
    if (cmd == CMD_READ) begin
      if (present) begin
        res.value   = value_slots[slot];
        res.present = 1'b1;
      end
    end else if (present) begin
      value_slots[slot] = wr_value;
      res.present = 1'b1;
    end else if (stored_total >= NZ_CAPACITY_DEF) begin
      res.status = ST_FULL;
    end else begin
      // Open a gap at the insert slot by moving every later value up by one.
      for (int m = stored_total; m > int'(slot); m--) value_slots[m] = value_slots[m - 1];
      value_slots[slot] = wr_value;
      stored_total++;
      row_table[row][col] = 1'b1;
      for (int r = int'(row) + 1; r < ROWS_DEF; r++)
        row_table[r][31:24] = row_table[r][31:24] + 8'd1;
    end
  endtask

  always @(posedge clk) begin : track
    access_result_t got;
    access_result_t want;
    if (rst) begin
      foreach (row_table[i]) row_table[i] = '0;
      foreach (value_slots[i]) value_slots[i] = '0;
      stored_total = 0;
      col_limit = NUM_COLS_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) col_limit = cfg_data;
      if (rsp.valid && rsp.ready) begin
        got.value   = rsp.read_value;
        got.present = rsp.was_present;
        got.status  = rsp.status;
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no item waiting");
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("read_value got %h want %h", got.value, want.value));
          if (got.present !== want.present)
            report_mismatch($sformatf("was_present got %b want %b", got.present, want.present));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        end
      end
      if (req.valid && req.ready) begin
        predict_access(req.command, req.row_index, req.col_index, req.write_value, want);
        expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== dv/tb_bitmap_sparse_matrix_store_core.sv =====
module tb_bitmap_sparse_matrix_store_core;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [COL_IN_W-1:0] cfg_data;
  int                  fail_count;
  int                  outstanding;
  int                  cycle_count = 0;
  int                  cur_cols = 24;
  bit                  src_quiet;
  bit                  snk_quiet;
  int                  src_items = 0;
  int                  snk_items = 0;

  bsm_req_if req_ch ();
  bsm_rsp_if rsp_ch ();

  bitmap_sparse_matrix_store_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  bsm_store_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bitmap_sparse_matrix_store_core");
      $finish;
    end
  end

  // Valid is only lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send_access(input logic cmd, input logic [ROW_IN_W-1:0] row,
                             input logic [COL_IN_W-1:0] col, input logic [DATA_W-1:0] value);
    int gap;
    if (src_items % 32 == 0) src_quiet = ($urandom_range(0, 3) == 0);
    src_items++;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.row_index   <= row;
    req_ch.col_index   <= col;
    req_ch.write_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_columns(input int cols);
    wait_idle();
    cur_cols = cols;
    cfg_we   <= 1'b1;
    cfg_data <= COL_IN_W'(cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic mixed_phase(input int count, input int write_pct);
    int                  eff;
    logic [COL_IN_W-1:0] col;
    logic                cmd;
    eff = (cur_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cur_cols;
    repeat (count) begin
      // A tenth of the items may land on any column, in range or not.
      if (eff == 0 || $urandom_range(0, 9) == 0) col = COL_IN_W'($urandom_range(0, 31));
      else col = COL_IN_W'($urandom_range(0, eff - 1));
      cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_READ;
      send_access(cmd, ROW_IN_W'($urandom_range(0, ROWS_DEF - 1)), col, pick_value());
    end
  endtask

  // Writes every cell once in shuffled order, so the store runs full partway through.
  task automatic fill_phase();
    int order [ROWS_DEF * MAX_COLS_DEF];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = ROWS_DEF * MAX_COLS_DEF - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i])
      send_access(CMD_WRITE, ROW_IN_W'(order[i] / MAX_COLS_DEF),
                  COL_IN_W'(order[i] % MAX_COLS_DEF), pick_value());
  endtask

  initial begin : responder
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (snk_items % 32 == 0) snk_quiet = ($urandom_range(0, 3) == 0);
      snk_items++;
      gap = snk_quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_READ;
    req_ch.row_index   <= '0;
    req_ch.col_index   <= '0;
    req_ch.write_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_columns(24);
    send_access(CMD_READ,  4'd0,  5'd0,  '0);
    send_access(CMD_WRITE, 4'd0,  5'd0,  32'h7FFF_FFFF);
    send_access(CMD_READ,  4'd0,  5'd0,  '0);
    send_access(CMD_WRITE, 4'd15, 5'd23, 32'h8000_0000);
    send_access(CMD_READ,  4'd15, 5'd23, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 4'd0,  5'd0,  32'hFFFF_FFFF);
    send_access(CMD_READ,  4'd0,  5'd0,  '0);
    // A zero written to an absent entry is stored and reads back as present.
    send_access(CMD_WRITE, 4'd7,  5'd12, '0);
    send_access(CMD_READ,  4'd7,  5'd12, '0);
    send_access(CMD_WRITE, 4'd0,  5'd5,  32'h1234_5678);
    send_access(CMD_READ,  4'd15, 5'd23, '0);
    send_access(CMD_WRITE, 4'd3,  5'd24, 32'hDEAD_BEEF);
    send_access(CMD_READ,  4'd15, 5'd31, '0);
    send_access(CMD_WRITE, 4'd15, 5'd0,  32'h5555_5555);
    send_access(CMD_READ,  4'd15, 5'd0,  '0);
    send_access(CMD_READ,  4'd8,  5'd8,  '0);

    // With no columns in use every access is out of range.
    set_columns(0);
    send_access(CMD_WRITE, 4'd0,  5'd0,  32'h0000_0001);
    send_access(CMD_READ,  4'd0,  5'd0,  '0);

    // A register value above the maximum acts as the maximum.
    set_columns(31);
    send_access(CMD_WRITE, 4'd3,  5'd23, 32'hAAAA_AAAA);
    send_access(CMD_READ,  4'd3,  5'd24, '0);
    send_access(CMD_READ,  4'd3,  5'd23, '0);

    set_columns(1);
    send_access(CMD_READ,  4'd0,  5'd0,  '0);
    send_access(CMD_WRITE, 4'd2,  5'd1,  32'h0000_0002);
    send_access(CMD_WRITE, 4'd2,  5'd0,  32'h0000_0001);

    set_columns($urandom_range(2, 23));
    mixed_phase(200, 60);
    set_columns(31);
    mixed_phase(150, 50);
    set_columns(24);
    fill_phase();
    mixed_phase(200, 50);
    set_columns($urandom_range(0, 31));
    mixed_phase(150, 40);
    set_columns(24);
    mixed_phase(150, 60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bitmap_sparse_matrix_store_core");
    end else begin
      $display("FAIL bitmap_sparse_matrix_store_core");
    end
    $finish;
  end

endmodule
